[rtl/fwsl_pkg.sv]
// shared constants for the four-wire serial link master
`timescale 1ns / 1ps
`default_nettype none

package fwsl_pkg;

  // payload buffer depth and derived widths
  localparam int BUF_SIZE = 32;
  localparam int IDX_W    = 5;
  localparam int LEN_W    = $clog2(BUF_SIZE + 1);
  localparam logic [7:0] BUF_SIZE_B = 8'(BUF_SIZE);

  // host opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_ACK   = 2'd3;

  // link status codes
  localparam logic [2:0] LS_IDLE       = 3'd0;
  localparam logic [2:0] LS_REQ        = 3'd1;
  localparam logic [2:0] LS_RUNNING    = 3'd2;
  localparam logic [2:0] LS_DATA_READY = 3'd3;
  localparam logic [2:0] LS_HAS_DATA   = 3'd4;
  localparam logic [2:0] LS_CYCLE_DONE = 3'd5;

  // configuration register indexes
  localparam logic REG_PHASE_HI = 1'b0;
  localparam logic REG_PHASE_LO = 1'b1;

  // phase register value minus one, zero acting as one
  function automatic logic [7:0] phase_m1(input logic [7:0] v);
    phase_m1 = (v == 8'd0) ? 8'd0 : v - 8'd1;
  endfunction

endpackage

`default_nettype wire

[rtl/fwsl_if.sv]
// valid/ready channel interfaces for host ticks and link results
`timescale 1ns / 1ps
`default_nettype none

interface fwsl_in_if
  import fwsl_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [1:0]       opcode;
  logic [7:0]       host_byte;
  logic [IDX_W-1:0] load_index;
  logic [7:0]       payload_length;
  logic             ack_line;
  logic             data_line;

  modport source (output valid, opcode, host_byte, load_index, payload_length,
                  ack_line, data_line, input ready);
  modport sink   (input valid, opcode, host_byte, load_index, payload_length,
                  ack_line, data_line, output ready);
endinterface

interface fwsl_out_if
  import fwsl_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             clock_out;
  logic             data_out;
  logic             data_drive;
  logic             request_out;
  logic [2:0]       link_status;
  logic [7:0]       slave_status;
  logic [7:0]       rx_byte;
  logic             rx_valid;
  logic [IDX_W-1:0] rx_position;
  logic [LEN_W-1:0] rx_count;
  logic             rejected;

  modport source (output valid, clock_out, data_out, data_drive, request_out,
                  link_status, slave_status, rx_byte, rx_valid, rx_position,
                  rx_count, rejected, input ready);
  modport sink   (input valid, clock_out, data_out, data_drive, request_out,
                  link_status, slave_status, rx_byte, rx_valid, rx_position,
                  rx_count, rejected, output ready);
endinterface

`default_nettype wire

[rtl/four_wire_serial_link_master.sv]
// four-wire serial link master: tick engine, payload buffer and config port
// the result beat for an accepted tick beat is registered, valid in the next cycle
// one tick per clock cycle while the sink is ready, set by the single state
// update path; the result register frees as it is taken, so no bubbles
// reset: asynchronous, active low; link idle, clock and data lines high,
// request low, phase registers at 4, payload buffer cleared
`timescale 1ns / 1ps
`default_nettype none

module four_wire_serial_link_master
  import fwsl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  fwsl_in_if.sink          in_i,
  fwsl_out_if.source       out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [2:0] {
    ST_WAIT, ST_ACK_WAIT, ST_SEND_CMD, ST_SEND_LEN, ST_SEND_PL,
    ST_RCV_LEN, ST_RCV_DATA, ST_REPLY
  } phase_e;

  // configuration registers
  logic [7:0] phase_hi_q, phase_lo_q;

  // link state
  phase_e           ps_q, ps_d;
  logic [2:0]       ls_q, ls_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [LEN_W-1:0] slen_q, slen_d, rlen_q, rlen_d;
  logic [LEN_W-1:0] sptr_q, sptr_d, rptr_q, rptr_d;
  logic [7:0]       sstat_q, sstat_d;
  logic             clk_q, clk_d, dta_q, dta_d, drv_q, drv_d, req_q, req_d;
  logic [1:0]       bph_q, bph_d;
  logic [3:0]       bnum_q, bnum_d;
  logic [7:0]       rem_q, rem_d;
  logic [7:0]       sh_q, sh_d;
  logic [7:0]       buf_q [BUF_SIZE];

  // per-tick results
  logic [7:0]       rxb_d;
  logic             rxv_d, rej_d, buf_we, done, sending;
  logic [IDX_W-1:0] rxp_d;
  logic [7:0]       tx;

  // output register
  logic             ovalid_q;
  logic             accept;

  assign in_i.ready = !ovalid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // apb port
  assign pready = 1'b1;
  assign prdata = {24'd0, (paddr[2] == REG_PHASE_LO) ? phase_lo_q : phase_hi_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_hi_q <= 8'd4;
      phase_lo_q <= 8'd4;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_PHASE_HI) begin
        phase_hi_q <= pwdata[7:0];
      end else begin
        phase_lo_q <= pwdata[7:0];
      end
    end
  end

  // byte to shift out in the current send phase
  always_comb begin
    case (ps_q)
      ST_SEND_CMD: tx = cmd_q;
      ST_SEND_LEN: tx = 8'(slen_q);
      default:     tx = buf_q[sptr_q[IDX_W-1:0]];
    endcase
  end

  assign sending = (ps_q == ST_SEND_CMD) || (ps_q == ST_SEND_LEN) ||
                   (ps_q == ST_SEND_PL);

  // link engine step followed by the host opcode
  always_comb begin
    ps_d    = ps_q;
    ls_d    = ls_q;
    cmd_d   = cmd_q;
    slen_d  = slen_q;
    rlen_d  = rlen_q;
    sptr_d  = sptr_q;
    rptr_d  = rptr_q;
    sstat_d = sstat_q;
    clk_d   = clk_q;
    dta_d   = dta_q;
    drv_d   = drv_q;
    req_d   = req_q;
    bph_d   = bph_q;
    bnum_d  = bnum_q;
    rem_d   = rem_q;
    sh_d    = sh_q;
    rxb_d   = 8'd0;
    rxv_d   = 1'b0;
    rxp_d   = '0;
    rej_d   = 1'b0;
    buf_we  = 1'b0;
    done    = 1'b0;

    case (ps_q)
      ST_WAIT: begin
        if (!in_i.ack_line && ls_q == LS_REQ) begin
          drv_d = 1'b1;
          req_d = 1'b1;
          ls_d  = LS_RUNNING;
          ps_d  = ST_ACK_WAIT;
        end
      end
      ST_ACK_WAIT: begin
        if (in_i.ack_line) begin
          ps_d   = ST_SEND_CMD;
          sptr_d = '0;
          rptr_d = '0;
          bph_d  = 2'd0;
        end
      end
      default: begin
        // bit engine: start tick, first half, second half
        if (bph_q == 2'd0) begin
          sh_d   = sending ? tx : 8'd0;
          bnum_d = 4'd0;
          bph_d  = 2'd1;
          clk_d  = 1'b0;
          if (sending) begin
            dta_d = sh_d[7];
            rem_d = phase_m1(phase_hi_q);
          end else begin
            rem_d = phase_m1(phase_lo_q);
          end
        end else if (rem_q != 8'd0) begin
          rem_d = rem_q - 8'd1;
        end else if (bph_q == 2'd1) begin
          if (!sending) begin
            sh_d = {sh_q[6:0], in_i.data_line};
          end
          clk_d = 1'b1;
          bph_d = 2'd2;
          rem_d = phase_m1(sending ? phase_lo_q : phase_hi_q);
        end else begin
          if (sending) begin
            sh_d = {sh_q[6:0], 1'b0};
          end
          bnum_d = bnum_q + 4'd1;
          if (bnum_d < 4'd8) begin
            bph_d = 2'd1;
            clk_d = 1'b0;
            if (sending) begin
              dta_d = sh_d[7];
              rem_d = phase_m1(phase_hi_q);
            end else begin
              rem_d = phase_m1(phase_lo_q);
            end
          end else begin
            clk_d = 1'b1;
            dta_d = 1'b1;
            bph_d = 2'd0;
            done  = 1'b1;
          end
        end

        // byte completion moves the transfer on
        if (done) begin
          case (ps_q)
            ST_SEND_CMD: ps_d = ST_SEND_LEN;
            ST_SEND_LEN: ps_d = ST_SEND_PL;
            ST_SEND_PL: begin
              sptr_d = sptr_q + LEN_W'(1);
              if (sptr_d == slen_q) begin
                drv_d = 1'b0;
                ps_d  = cmd_q[7] ? ST_RCV_LEN : ST_REPLY;
              end
            end
            ST_RCV_LEN: begin
              if (sh_d == 8'd0 || sh_d > BUF_SIZE_B) begin
                rlen_d = LEN_W'(1);
              end else begin
                rlen_d = sh_d[LEN_W-1:0];
              end
              ps_d = ST_RCV_DATA;
            end
            ST_RCV_DATA: begin
              rxb_d  = sh_d;
              rxv_d  = 1'b1;
              rxp_d  = rptr_q[IDX_W-1:0];
              rptr_d = rptr_q + LEN_W'(1);
              if (rptr_d == rlen_q) begin
                ls_d = LS_HAS_DATA;
                ps_d = ST_REPLY;
              end
            end
            default: begin
              sstat_d = sh_d;
              req_d   = 1'b0;
              ls_d    = (ls_q == LS_HAS_DATA) ? LS_DATA_READY : LS_CYCLE_DONE;
              ps_d    = ST_WAIT;
            end
          endcase
        end
      end
    endcase

    // host opcode sees the status left by the engine
    case (in_i.opcode)
      OP_LOAD: begin
        if (ls_d != LS_IDLE || {3'd0, in_i.load_index} >= BUF_SIZE_B) begin
          rej_d = 1'b1;
        end else begin
          buf_we = 1'b1;
        end
      end
      OP_START: begin
        if (ls_d != LS_IDLE || in_i.payload_length == 8'd0 ||
            in_i.payload_length > BUF_SIZE_B) begin
          rej_d = 1'b1;
        end else begin
          cmd_d  = in_i.host_byte;
          slen_d = in_i.payload_length[LEN_W-1:0];
          sptr_d = '0;
          ls_d   = LS_REQ;
        end
      end
      OP_ACK: begin
        if (ps_d == ST_WAIT) begin
          ls_d = LS_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  // state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q     <= ST_WAIT;
      ls_q     <= LS_IDLE;
      cmd_q    <= 8'd0;
      slen_q   <= '0;
      rlen_q   <= '0;
      sptr_q   <= '0;
      rptr_q   <= '0;
      sstat_q  <= 8'd0;
      clk_q    <= 1'b1;
      dta_q    <= 1'b1;
      drv_q    <= 1'b0;
      req_q    <= 1'b0;
      bph_q    <= 2'd0;
      bnum_q   <= 4'd0;
      rem_q    <= 8'd0;
      sh_q     <= 8'd0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < BUF_SIZE; i++) begin
        buf_q[i] <= 8'd0;
      end
    end else begin
      if (accept) begin
        ps_q     <= ps_d;
        ls_q     <= ls_d;
        cmd_q    <= cmd_d;
        slen_q   <= slen_d;
        rlen_q   <= rlen_d;
        sptr_q   <= sptr_d;
        rptr_q   <= rptr_d;
        sstat_q  <= sstat_d;
        clk_q    <= clk_d;
        dta_q    <= dta_d;
        drv_q    <= drv_d;
        req_q    <= req_d;
        bph_q    <= bph_d;
        bnum_q   <= bnum_d;
        rem_q    <= rem_d;
        sh_q     <= sh_d;
        ovalid_q <= 1'b1;
        if (buf_we) begin
          buf_q[in_i.load_index] <= in_i.host_byte;
        end
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted tick
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_o.clock_out    <= clk_d;
      out_o.data_out     <= dta_d;
      out_o.data_drive   <= drv_d;
      out_o.request_out  <= req_d;
      out_o.link_status  <= ls_d;
      out_o.slave_status <= sstat_d;
      out_o.rx_byte      <= rxb_d;
      out_o.rx_valid     <= rxv_d;
      out_o.rx_position  <= rxp_d;
      out_o.rx_count     <= (ls_d == LS_HAS_DATA) ? rlen_d : '0;
      out_o.rejected     <= rej_d;
    end
  end

  assign out_o.valid = ovalid_q;

endmodule

`default_nettype wire

[verif/four_wire_serial_link_master_test.sv]
// self-checking testbench for the four-wire serial link master
`timescale 1ns / 1ps

module four_wire_serial_link_master_test;
  import fwsl_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  // sequencer states of the link engine
  typedef enum logic [3:0] {
    SEQ_WAIT, SEQ_ACK_WAIT, SEQ_SEND_CMD, SEQ_SEND_LEN, SEQ_SEND_PL,
    SEQ_RCV_LEN, SEQ_RCV_DATA, SEQ_REPLY
  } seq_e;

  // position within one byte on the wire
  typedef enum logic [1:0] {BIT_START, BIT_FIRST, BIT_SECOND} bit_half_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [7:0]       host_byte;
    logic [IDX_W-1:0] load_index;
    logic [7:0]       payload_length;
    logic             ack_line;
    logic             data_line;
  } tick_t;

  typedef struct packed {
    logic             clock_out;
    logic             data_out;
    logic             data_drive;
    logic             request_out;
    logic [2:0]       link_status;
    logic [7:0]       slave_status;
    logic [7:0]       rx_byte;
    logic             rx_valid;
    logic [IDX_W-1:0] rx_position;
    logic [LEN_W-1:0] rx_count;
    logic             rejected;
  } line_state_t;

  typedef struct packed {
    logic [7:0]               hi_ticks;
    logic [7:0]               lo_ticks;
    seq_e                     seq;
    logic [2:0]               link;
    logic [7:0]               cmd;
    logic [7:0]               tx_len;
    logic [7:0]               rx_len;
    logic [7:0]               tx_ptr;
    logic [7:0]               rx_ptr;
    logic [7:0]               status;
    logic [BUF_SIZE-1:0][7:0] buffer;
    logic                     clk_lvl;
    logic                     dat_lvl;
    logic                     drive;
    logic                     req;
    bit_half_e                half;
    logic [3:0]               bit_idx;
    logic [7:0]               ticks_left;
    logic [7:0]               shifter;
  } link_model_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;

  logic  tick_valid = 1'b0;
  tick_t tick_bus = '0;
  logic  result_ready = 1'b0;

  fwsl_in_if  in_ch ();
  fwsl_out_if out_ch ();

  assign in_ch.valid = tick_valid;
  assign {in_ch.opcode, in_ch.host_byte, in_ch.load_index, in_ch.payload_length,
          in_ch.ack_line, in_ch.data_line} = tick_bus;
  assign out_ch.ready = result_ready;

  four_wire_serial_link_master dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predicted link, and a second copy that plans the stimulus ahead
  link_model_t link_now;
  link_model_t link_plan;
  logic [7:0]  planned_rx_len;

  tick_t       ticks_to_send[$];
  line_state_t line_states_due[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int beats_in = 0;
  int results_seen = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  int hold_mark = 0;
  bit hold_used = 1'b0;
  bit pressure_armed = 1'b0;

  function automatic link_model_t model_reset();
    link_model_t m;
    m = '0;
    m.hi_ticks = 8'd4;
    m.lo_ticks = 8'd4;
    m.seq = SEQ_WAIT;
    m.link = LS_IDLE;
    m.clk_lvl = 1'b1;
    m.dat_lvl = 1'b1;
    m.half = BIT_START;
    return m;
  endfunction

  // extra ticks a half bit lasts, a zero register counting as one
  function automatic logic [7:0] hold_count(input logic [7:0] ticks);
    return (ticks == 8'd0) ? 8'd0 : ticks - 8'd1;
  endfunction

  // clock low at the start of a bit, data set first when sending
  function automatic void start_bit(inout link_model_t m, input logic sending);
    m.half = BIT_FIRST;
    m.clk_lvl = 1'b0;
    if (sending) begin
      m.dat_lvl = m.shifter[7];
      m.ticks_left = hold_count(m.hi_ticks);
    end else begin
      m.ticks_left = hold_count(m.lo_ticks);
    end
  endfunction

  // one tick of the bit engine, true when the closing tick of a byte is done
  function automatic logic clock_byte(inout link_model_t m, input logic sending,
                                      input logic [7:0] tx, input logic dline);
    if (m.half == BIT_START) begin
      m.shifter = sending ? tx : 8'h00;
      m.bit_idx = 4'd0;
      start_bit(m, sending);
      return 1'b0;
    end
    if (m.ticks_left != 8'd0) begin
      m.ticks_left = m.ticks_left - 8'd1;
      return 1'b0;
    end
    // end of the first half: sample when listening, then clock high
    if (m.half == BIT_FIRST) begin
      if (!sending) m.shifter = {m.shifter[6:0], dline};
      m.clk_lvl = 1'b1;
      m.half = BIT_SECOND;
      m.ticks_left = hold_count(sending ? m.lo_ticks : m.hi_ticks);
      return 1'b0;
    end
    if (sending) m.shifter = m.shifter << 1;
    m.bit_idx = m.bit_idx + 4'd1;
    if (m.bit_idx < 4'd8) begin
      start_bit(m, sending);
      return 1'b0;
    end
    m.clk_lvl = 1'b1;
    m.dat_lvl = 1'b1;
    m.half = BIT_START;
    return 1'b1;
  endfunction

  // link engine first, then the host opcode, then the line levels
  function automatic line_state_t link_step(inout link_model_t m, input tick_t t);
    line_state_t r;
    logic [7:0]  tx;
    r = '0;
    case (m.seq)
      SEQ_WAIT: begin
        if (!t.ack_line && m.link == LS_REQ) begin
          m.drive = 1'b1;
          m.req = 1'b1;
          m.link = LS_RUNNING;
          m.seq = SEQ_ACK_WAIT;
        end
      end
      SEQ_ACK_WAIT: begin
        if (t.ack_line) begin
          m.seq = SEQ_SEND_CMD;
          m.tx_ptr = 8'd0;
          m.rx_ptr = 8'd0;
          m.half = BIT_START;
        end
      end
      SEQ_SEND_CMD, SEQ_SEND_LEN, SEQ_SEND_PL: begin
        case (m.seq)
          SEQ_SEND_CMD: tx = m.cmd;
          SEQ_SEND_LEN: tx = m.tx_len;
          default:      tx = m.buffer[m.tx_ptr[IDX_W-1:0]];
        endcase
        if (clock_byte(m, 1'b1, tx, t.data_line)) begin
          if (m.seq == SEQ_SEND_CMD) begin
            m.seq = SEQ_SEND_LEN;
          end else if (m.seq == SEQ_SEND_LEN) begin
            m.seq = SEQ_SEND_PL;
          end else begin
            m.tx_ptr = m.tx_ptr + 8'd1;
            if (m.tx_ptr == m.tx_len) begin
              m.drive = 1'b0;
              m.seq = m.cmd[7] ? SEQ_RCV_LEN : SEQ_REPLY;
            end
          end
        end
      end
      default: begin
        if (clock_byte(m, 1'b0, 8'h00, t.data_line)) begin
          if (m.seq == SEQ_RCV_LEN) begin
            // out-of-range receive length falls back to one byte
            m.rx_len = (m.shifter == 8'd0 || m.shifter > BUF_SIZE_B) ? 8'd1 : m.shifter;
            m.seq = SEQ_RCV_DATA;
          end else if (m.seq == SEQ_RCV_DATA) begin
            r.rx_byte = m.shifter;
            r.rx_valid = 1'b1;
            r.rx_position = m.rx_ptr[IDX_W-1:0];
            m.rx_ptr = m.rx_ptr + 8'd1;
            if (m.rx_ptr == m.rx_len) begin
              m.link = LS_HAS_DATA;
              m.seq = SEQ_REPLY;
            end
          end else begin
            m.status = m.shifter;
            m.req = 1'b0;
            m.link = (m.link == LS_HAS_DATA) ? LS_DATA_READY : LS_CYCLE_DONE;
            m.seq = SEQ_WAIT;
          end
        end
      end
    endcase

    case (t.opcode)
      OP_LOAD: begin
        if (m.link != LS_IDLE || int'(t.load_index) >= BUF_SIZE) r.rejected = 1'b1;
        else m.buffer[t.load_index] = t.host_byte;
      end
      OP_START: begin
        if (m.link != LS_IDLE || t.payload_length == 8'd0 ||
            t.payload_length > BUF_SIZE_B) begin
          r.rejected = 1'b1;
        end else begin
          m.cmd = t.host_byte;
          m.tx_len = t.payload_length;
          m.tx_ptr = 8'd0;
          m.link = LS_REQ;
        end
      end
      OP_ACK: begin
        if (m.seq == SEQ_WAIT) m.link = LS_IDLE;
      end
      default: ;
    endcase

    r.clock_out = m.clk_lvl;
    r.data_out = m.dat_lvl;
    r.data_drive = m.drive;
    r.request_out = m.req;
    r.link_status = m.link;
    r.slave_status = m.status;
    r.rx_count = (m.link == LS_HAS_DATA) ? m.rx_len[LEN_W-1:0] : '0;
    return r;
  endfunction

  // mostly short lengths, sometimes the full buffer, sometimes out of range
  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 8'($urandom_range(1, 4));
    if (r < 75) return BUF_SIZE_B;
    if (r < 88) return 8'($urandom_range(5, BUF_SIZE - 1));
    if (r < 94) return 8'd0;
    return 8'($urandom_range(BUF_SIZE + 1, 255));
  endfunction

  function automatic tick_t mk_tick(input logic [1:0] op, input logic [7:0] hb,
                                    input logic [IDX_W-1:0] idx, input logic [7:0] plen,
                                    input logic ack, input logic dline);
    tick_t t;
    t = {op, hb, idx, plen, ack, dline};
    return t;
  endfunction

  // steer the next tick by where the planned link stands
  function automatic tick_t next_planned_tick();
    tick_t t;
    int    r;
    t = mk_tick(2'($urandom_range(0, 3)), 8'($urandom), IDX_W'($urandom),
                8'($urandom), 1'($urandom), 1'($urandom));
    if ($urandom_range(0, 99) < 6) return t;
    t.opcode = OP_TICK;
    r = $urandom_range(0, 99);
    case (link_plan.seq)
      SEQ_WAIT: begin
        if (link_plan.link == LS_IDLE) begin
          if (r < 40) begin
            t.opcode = OP_LOAD;
          end else if (r < 70) begin
            t.opcode = OP_START;
            t.payload_length = pick_len();
            planned_rx_len = pick_len();
          end
        end else if (link_plan.link == LS_REQ) begin
          t.ack_line = (r >= 80);
          if (r >= 95) t.opcode = OP_ACK;
        end else if (r < 60) begin
          t.opcode = OP_ACK;
        end
      end
      SEQ_ACK_WAIT: t.ack_line = (r < 80);
      SEQ_RCV_LEN: begin
        if (link_plan.bit_idx < 4'd8) t.data_line = planned_rx_len[7 - link_plan.bit_idx];
      end
      default: ;
    endcase
    // host noise during a transfer
    if (link_plan.seq != SEQ_WAIT && r >= 92) t.opcode = 2'($urandom_range(1, 3));
    return t;
  endfunction

  task automatic queue_tick(input tick_t t);
    void'(link_step(link_plan, t));
    ticks_to_send.push_back(t);
  endtask

  task automatic write_phase_reg(input logic sel, input logic [7:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_PHASE_HI) begin
      link_now.hi_ticks = value;
      link_plan.hi_ticks = value;
    end else begin
      link_now.lo_ticks = value;
      link_plan.lo_ticks = value;
    end
  endtask

  task automatic drain();
    while (ticks_to_send.size() != 0 || tick_valid || line_states_due.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [7:0] hi, input logic [7:0] lo, input int n,
                           input int idle, input int stall, input bit press);
    write_phase_reg(REG_PHASE_HI, hi);
    write_phase_reg(REG_PHASE_LO, lo);
    send_idle_pct = idle;
    stall_pct = stall;
    if (press) begin
      hold_mark = beats_in + 40;
      pressure_armed = 1'b1;
    end
    repeat (n) queue_tick(next_planned_tick());
    drain();
  endtask

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  // tick source: offers queued beats, random gaps between them
  always @(posedge clk_i) begin : drive_ticks
    if (!rst_ni) begin
      tick_valid <= 1'b0;
    end else begin
      if (tick_valid && in_ch.ready) begin
        line_states_due.push_back(link_step(link_now, tick_bus));
        beats_in <= beats_in + 1;
      end
      if (!tick_valid || in_ch.ready) begin
        if (ticks_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          tick_valid <= 1'b1;
          tick_bus <= ticks_to_send.pop_front();
        end else begin
          tick_valid <= 1'b0;
        end
      end
    end
  end

  // result sink: random stalls plus one long hold-off to back the block up
  always @(posedge clk_i) begin : pace_results
    if (!rst_ni) begin
      result_ready <= 1'b0;
    end else if (pressure_armed && !hold_used && beats_in >= hold_mark) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
      result_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk_i) begin : check_lines
    line_state_t seen;
    line_state_t want;
    if (rst_ni && out_ch.valid && result_ready) begin
      seen = {out_ch.clock_out, out_ch.data_out, out_ch.data_drive, out_ch.request_out,
              out_ch.link_status, out_ch.slave_status, out_ch.rx_byte, out_ch.rx_valid,
              out_ch.rx_position, out_ch.rx_count, out_ch.rejected};
      if (line_states_due.size() == 0) begin
        if (mismatches < 10) $display("result beat %0d arrived with nothing predicted",
                                      results_seen);
        mismatches = mismatches + 1;
      end else begin
        want = line_states_due.pop_front();
        if (seen !== want) begin
          if (mismatches < 10) begin
            $display("beat %0d expected: clk %b dat %b drv %b req %b st %0d slv %h rx %h v %b pos %0d cnt %0d rej %b",
                     results_seen, want.clock_out, want.data_out, want.data_drive,
                     want.request_out, want.link_status, want.slave_status, want.rx_byte,
                     want.rx_valid, want.rx_position, want.rx_count, want.rejected);
            $display("beat %0d actual:   clk %b dat %b drv %b req %b st %0d slv %h rx %h v %b pos %0d cnt %0d rej %b",
                     results_seen, seen.clock_out, seen.data_out, seen.data_drive,
                     seen.request_out, seen.link_status, seen.slave_status, seen.rx_byte,
                     seen.rx_valid, seen.rx_position, seen.rx_count, seen.rejected);
          end
          mismatches = mismatches + 1;
        end
      end
      results_seen = results_seen + 1;
    end
  end

  // stop a hung run: cycles with work outstanding but no beat moving
  always @(posedge clk_i) begin : watchdog
    if ((tick_valid && in_ch.ready) || (out_ch.valid && result_ready) ||
        (ticks_to_send.size() == 0 && line_states_due.size() == 0 && !tick_valid)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : run_test
    link_now = model_reset();
    link_plan = model_reset();
    planned_rx_len = 8'd0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // refused starts: zero length, just over the buffer, largest length
    queue_tick(mk_tick(OP_START, 8'h12, '0, 8'd0, 1'b1, 1'b0));
    queue_tick(mk_tick(OP_START, 8'h34, '0, BUF_SIZE_B + 8'd1, 1'b1, 1'b0));
    queue_tick(mk_tick(OP_START, 8'h56, '0, 8'd255, 1'b1, 1'b1));
    // loads at both ends of the buffer with extreme bytes
    queue_tick(mk_tick(OP_LOAD, 8'hFF, '1, 8'd0, 1'b1, 1'b0));
    queue_tick(mk_tick(OP_LOAD, 8'h00, '0, 8'd0, 1'b1, 1'b1));
    queue_tick(mk_tick(OP_LOAD, 8'hA5, IDX_W'(1), 8'd0, 1'b1, 1'b0));
    queue_tick(mk_tick(OP_ACK, 8'h00, '0, 8'd0, 1'b1, 1'b0));
    queue_tick(mk_tick(OP_TICK, 8'h00, '0, 8'd0, 1'b1, 1'b0));
    // pending request cancelled by an acknowledge while ack is high
    queue_tick(mk_tick(OP_START, 8'h00, '0, 8'd1, 1'b1, 1'b0));
    queue_tick(mk_tick(OP_ACK, 8'h00, '0, 8'd0, 1'b1, 1'b0));
    // read transfer with a zero receive length, refused ops while busy
    planned_rx_len = 8'd0;
    queue_tick(mk_tick(OP_START, 8'hFF, '0, 8'd2, 1'b1, 1'b0));
    queue_tick(mk_tick(OP_LOAD, 8'h3C, IDX_W'(5), 8'd0, 1'b1, 1'b0));
    queue_tick(mk_tick(OP_START, 8'h81, '0, 8'd4, 1'b1, 1'b0));
    queue_tick(mk_tick(OP_ACK, 8'h00, '0, 8'd0, 1'b0, 1'b0));
    queue_tick(mk_tick(OP_TICK, 8'h00, '0, 8'd0, 1'b0, 1'b0));
    queue_tick(mk_tick(OP_TICK, 8'h00, '0, 8'd0, 1'b0, 1'b1));
    queue_tick(mk_tick(OP_ACK, 8'h00, '0, 8'd0, 1'b1, 1'b0));
    repeat (4) queue_tick(next_planned_tick());
    drain();

    run_phase(8'd1, 8'd1, 400, 0, 0, 1'b1);
    run_phase(8'd0, 8'd0, 280, 83, 0, 1'b0);
    run_phase(8'd2, 8'd5, 280, 0, 83, 1'b0);
    run_phase(8'd1, 8'd3, 280, 35, 35, 1'b0);
    run_phase(8'd255, 8'd1, 300, 0, 0, 1'b0);
    run_phase(8'd1, 8'd255, 300, 35, 35, 1'b0);

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && line_states_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
